// ----- rtl/lsme_pkg.sv -----
// ----------------------------------------------------------------------------
// lsme_pkg
// Shared types, opcodes and a helper function for the slot message engine.
// ----------------------------------------------------------------------------
package lsme_pkg;

    // Default sizes of the slot table and the message buffer.
    localparam int LSME_NUM_SLOTS = 16;
    localparam int LSME_MSG_BYTES = 16;

    // Opcodes and fixed bytes on the wire.
    localparam logic [7:0] OPC_PWR_ON_REQ  = 8'h83;
    localparam logic [7:0] OPC_PWR_OFF_REQ = 8'h82;
    localparam logic [7:0] OPC_RQ_SL     = 8'hBB;
    localparam logic [7:0] OPC_MOVE      = 8'hBA;
    localparam logic [7:0] OPC_STAT1     = 8'hB5;
    localparam logic [7:0] OPC_SPD       = 8'hA0;
    localparam logic [7:0] OPC_DIRF      = 8'hA1;
    localparam logic [7:0] OPC_SND       = 8'hA2;
    localparam logic [7:0] OPC_ADR       = 8'hBF;
    localparam logic [7:0] OPC_WR_SL     = 8'hEF;
    localparam logic [7:0] OPC_RD_SL     = 8'hE7;
    localparam logic [7:0] OPC_LACK      = 8'hB4;
    localparam logic [7:0] SLOT_PROG     = 8'h7C;
    localparam logic [7:0] SLOT_CLOCK    = 8'h7B;
    localparam logic [7:0] RD_LEN        = 8'h0E;
    localparam logic [7:0] LACK_OPC_ECHO = 8'hBF;
    localparam logic [7:0] LACK_CODE     = 8'h00;
    localparam logic [7:0] LACK_CHK      = 8'hF4;
    localparam logic [7:0] CHK_GOOD      = 8'hFF;
    localparam logic [7:0] STAT_IN_USE   = 8'h30;

    // Index of the last byte of each reply.
    localparam logic [3:0] E7_LAST   = 4'd13;
    localparam logic [3:0] LACK_LAST = 4'd3;

    // Decoded command of a finished message.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_PWR_ON,
        CMD_PWR_OFF,
        CMD_READ,
        CMD_LACK,
        CMD_NULL_MOVE,
        CMD_WR_STAT,
        CMD_WR_SPD,
        CMD_WR_DIRF,
        CMD_WR_SND,
        CMD_WR_SLOT,
        CMD_ADDR_REQ
    } t_cmd;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_WR,
        S_SCAN,
        S_SCAN_END,
        S_FETCH,
        S_LOAD,
        S_SEND,
        S_ASCAN,
        S_AEND,
        S_ADEC
    } t_state;

    // One slot record.
    typedef struct packed {
        logic [7:0]  status;
        logic [13:0] addr;
        logic        is_long;
        logic [6:0]  step;
        logic        fwd;
        logic [8:0]  func;
    } t_slot_rec;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic latch_cmd;
        logic pwr_set;
        logic rd_scan;
        logic scan_start;
        logic scan_step;
        logic wr_en;
        logic take_match;
        logic take_free;
        logic load_rep;
        logic out_start;
        logic out_lack;
        logic out_next;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd dec_cmd;
        t_cmd cmd;
        logic eom;
        logic scan_last;
        logic match_found;
        logic free_found;
        logic out_last;
    } t_stat;

    // Speed byte to internal step: 0 and 1 both mean stopped.
    function automatic logic [6:0] speed_step(input logic [7:0] v);
        logic [7:0] vm1;
        vm1 = v - 8'd1;
        speed_step = (v <= 8'd1) ? 7'd0 : vm1[6:0];
    endfunction

endpackage

// ----- rtl/lsme_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsme_ctrl
// Sequencer that steps the datapath through decode, slot updates, table
// scans and reply transfers.
// ----------------------------------------------------------------------------
module lsme_ctrl import lsme_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_ctl  o_ctl,
    output logic  o_in_stall,
    output logic  o_out_valid
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    if (i_stat.eom) begin
                        n_state = S_DECODE;
                    end
                end
            end
            S_DECODE: begin
                o_ctl.latch_cmd = 1'b1;
                case (i_stat.dec_cmd)
                    CMD_PWR_ON, CMD_PWR_OFF: begin
                        o_ctl.pwr_set = 1'b1;
                        n_state = S_IDLE;
                    end
                    CMD_READ:     n_state = S_SCAN;
                    CMD_ADDR_REQ: n_state = S_ASCAN;
                    CMD_LACK: begin
                        o_ctl.out_start = 1'b1;
                        o_ctl.out_lack  = 1'b1;
                        n_state = S_SEND;
                    end
                    CMD_NULL_MOVE, CMD_WR_STAT, CMD_WR_SPD, CMD_WR_DIRF,
                    CMD_WR_SND, CMD_WR_SLOT: n_state = S_RD;
                    default: n_state = S_IDLE;
                endcase
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                o_ctl.wr_en = 1'b1;
                if (i_stat.cmd == CMD_NULL_MOVE || i_stat.cmd == CMD_ADDR_REQ) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_ctl.rd_scan   = 1'b1;
                o_ctl.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_ctl.load_rep  = 1'b1;
                o_ctl.out_start = 1'b1;
                n_state = S_SEND;
            end
            S_SEND: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (i_stat.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.out_next = 1'b1;
                    end
                end
            end
            S_ASCAN: begin
                o_ctl.rd_scan   = 1'b1;
                o_ctl.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_AEND;
                end
            end
            S_AEND: begin
                n_state = S_ADEC;
            end
            S_ADEC: begin
                if (i_stat.match_found) begin
                    o_ctl.take_match = 1'b1;
                    n_state = S_SCAN;
                end else if (i_stat.free_found) begin
                    o_ctl.take_free = 1'b1;
                    n_state = S_RD;
                end else begin
                    o_ctl.out_start = 1'b1;
                    o_ctl.out_lack  = 1'b1;
                    n_state = S_SEND;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // A scan restarts its counter and flags on the way in.
        o_ctl.scan_start = (n_state == S_SCAN || n_state == S_ASCAN) && (r_state != n_state);
    end

endmodule

// ----- rtl/lsme_dp.sv -----
// ----------------------------------------------------------------------------
// lsme_dp
// Message buffer, checksum, slot table memory, scan logic and reply bytes.
// ----------------------------------------------------------------------------
module lsme_dp import lsme_pkg::*; #(
    parameter int NUM_SLOTS = LSME_NUM_SLOTS,
    parameter int MSG_BYTES = LSME_MSG_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctl       i_ctl,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_message,
    output t_stat      o_stat,
    output logic [7:0] o_reply_byte,
    output logic       o_reply_last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(MSG_BYTES + 1);
    localparam int MB_W  = $clog2(MSG_BYTES);

    // Message intake registers.
    logic [7:0]       r_msg [MSG_BYTES];
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_xor;
    logic             r_too_long;
    logic [CNT_W-1:0] r_len;
    logic             r_ok;
    logic [CNT_W-1:0] n_cnt;
    logic [7:0]       n_xor;
    logic             n_too_long;

    always_comb begin
        n_cnt      = r_cnt;
        n_too_long = r_too_long;
        if (r_cnt < CNT_W'(MSG_BYTES)) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else begin
            n_too_long = 1'b1;
        end
        n_xor = r_xor ^ i_in_byte;
    end

    // Store the byte and check the message at its end.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && r_cnt < CNT_W'(MSG_BYTES)) begin
            r_msg[r_cnt[MB_W-1:0]] <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_xor      <= '0;
            r_too_long <= 1'b0;
            r_len      <= '0;
            r_ok       <= 1'b0;
        end else if (i_ctl.accept) begin
            if (i_end_of_message) begin
                r_len      <= n_cnt;
                r_ok       <= !n_too_long && (n_xor == CHK_GOOD);
                r_cnt      <= '0;
                r_xor      <= '0;
                r_too_long <= 1'b0;
            end else begin
                r_cnt      <= n_cnt;
                r_xor      <= n_xor;
                r_too_long <= n_too_long;
            end
        end
    end

    // Decode of the finished message.
    t_cmd       dec_cmd;
    logic [7:0] dec_slot;
    logic       dec_slot_ok;
    logic [7:0] slot_m1;

    always_comb begin
        dec_cmd  = CMD_NONE;
        dec_slot = (r_len == CNT_W'(14)) ? r_msg[2] : r_msg[1];
        dec_slot_ok = (dec_slot >= 8'd1) && (dec_slot <= 8'(NUM_SLOTS));
        slot_m1 = dec_slot - 8'd1;
        if (r_ok) begin
            if (r_len == CNT_W'(2)) begin
                if (r_msg[0] == OPC_PWR_ON_REQ) begin
                    dec_cmd = CMD_PWR_ON;
                end else if (r_msg[0] == OPC_PWR_OFF_REQ) begin
                    dec_cmd = CMD_PWR_OFF;
                end
            end else if (r_len == CNT_W'(4)) begin
                case (r_msg[0])
                    OPC_RQ_SL: dec_cmd = dec_slot_ok ? CMD_READ : CMD_LACK;
                    OPC_ADR:   dec_cmd = CMD_ADDR_REQ;
                    OPC_MOVE: begin
                        if (dec_slot_ok && r_msg[1] == r_msg[2]) begin
                            dec_cmd = CMD_NULL_MOVE;
                        end
                    end
                    OPC_STAT1: if (dec_slot_ok) dec_cmd = CMD_WR_STAT;
                    OPC_SPD:   if (dec_slot_ok) dec_cmd = CMD_WR_SPD;
                    OPC_DIRF:  if (dec_slot_ok) dec_cmd = CMD_WR_DIRF;
                    OPC_SND:   if (dec_slot_ok) dec_cmd = CMD_WR_SND;
                    default:   dec_cmd = CMD_NONE;
                endcase
            end else if (r_len == CNT_W'(14) && r_msg[0] == OPC_WR_SL
                         && r_msg[2] != SLOT_PROG && r_msg[2] != SLOT_CLOCK
                         && dec_slot_ok) begin
                dec_cmd = CMD_WR_SLOT;
            end
        end
    end

    // Address request operands.
    logic        req_long;
    logic [14:0] req_sum;
    logic [13:0] req_addr;

    always_comb begin
        req_long = (r_msg[1] != 8'd0);
        req_sum  = {r_msg[1], 7'd0} + {7'd0, r_msg[2]};
        req_addr = req_long ? req_sum[13:0] : {6'd0, r_msg[2]};
    end

    // Latched command, slot index, power and scan results.
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [13:0]      r_req_addr;
    logic             r_req_long;
    logic             r_power;
    logic [IDX_W-1:0] r_scan;
    logic             r_eval;
    logic [IDX_W-1:0] r_eval_idx;
    logic             r_moving;
    logic             r_match_found;
    logic [IDX_W-1:0] r_match_idx;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;

    // Slot table memory with valid bits; an unwritten entry reads as zero.
    t_slot_rec        r_mem [NUM_SLOTS];
    logic             r_vld [NUM_SLOTS];
    t_slot_rec        r_rd_data;
    logic             r_rd_vld;
    t_slot_rec        rd_rec;
    t_slot_rec        wr_rec;
    logic [IDX_W-1:0] rd_addr;

    assign rd_addr = i_ctl.rd_scan ? r_scan : r_idx;
    assign rd_rec  = r_rd_vld ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[r_idx] <= wr_rec;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[r_idx] <= 1'b1;
            end
            r_rd_vld <= r_vld[rd_addr];
        end
    end

    // Read-modify-write of one slot record.
    always_comb begin
        wr_rec = rd_rec;
        case (r_cmd)
            CMD_NULL_MOVE: wr_rec.status = rd_rec.status | STAT_IN_USE;
            CMD_WR_STAT:   wr_rec.status = r_msg[2];
            CMD_WR_SPD:    wr_rec.step = speed_step(r_msg[2]);
            CMD_WR_DIRF: begin
                wr_rec.func[4:1] = r_msg[2][3:0];
                wr_rec.func[0]   = r_msg[2][4];
                wr_rec.fwd       = r_msg[2][5];
            end
            CMD_WR_SND:    wr_rec.func[8:5] = r_msg[2][3:0];
            CMD_WR_SLOT: begin
                wr_rec.status    = r_msg[3];
                wr_rec.step      = speed_step(r_msg[5]);
                wr_rec.func[4:1] = r_msg[6][3:0];
                wr_rec.func[0]   = r_msg[6][4];
                wr_rec.fwd       = r_msg[6][5];
                wr_rec.func[8:5] = r_msg[10][3:0];
            end
            CMD_ADDR_REQ: begin
                wr_rec.addr    = r_req_addr;
                wr_rec.is_long = r_req_long;
            end
            default: wr_rec = rd_rec;
        endcase
    end

    // Command latch, power flag and table scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd         <= CMD_NONE;
            r_power       <= 1'b0;
            r_eval        <= 1'b0;
            r_scan        <= '0;
            r_moving      <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end else begin
            if (i_ctl.latch_cmd) begin
                r_cmd <= dec_cmd;
            end
            if (i_ctl.pwr_set) begin
                r_power <= (dec_cmd == CMD_PWR_ON);
            end
            r_eval <= i_ctl.rd_scan;
            if (i_ctl.scan_start) begin
                r_scan        <= '0;
                r_moving      <= 1'b0;
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
            end else begin
                if (i_ctl.scan_step) begin
                    r_scan <= r_scan + IDX_W'(1);
                end
                if (r_eval) begin
                    if (rd_rec.addr != 14'd0 && rd_rec.step != 7'd0) begin
                        r_moving <= 1'b1;
                    end
                    if (!r_match_found && rd_rec.addr != 14'd0
                        && rd_rec.addr == r_req_addr && rd_rec.is_long == r_req_long) begin
                        r_match_found <= 1'b1;
                    end
                    if (!r_free_found && rd_rec.addr == 14'd0) begin
                        r_free_found <= 1'b1;
                    end
                end
            end
        end
    end

    // Payload side of the latch and scan; no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch_cmd) begin
            r_idx      <= slot_m1[IDX_W-1:0];
            r_req_addr <= req_addr;
            r_req_long <= req_long;
        end else if (i_ctl.take_match) begin
            r_idx <= r_match_idx;
        end else if (i_ctl.take_free) begin
            r_idx <= r_free_idx;
        end
        r_eval_idx <= r_scan;
        if (r_eval && !i_ctl.scan_start) begin
            if (!r_match_found && rd_rec.addr != 14'd0
                && rd_rec.addr == r_req_addr && rd_rec.is_long == r_req_long) begin
                r_match_idx <= r_eval_idx;
            end
            if (!r_free_found && rd_rec.addr == 14'd0) begin
                r_free_idx <= r_eval_idx;
            end
        end
    end

    // Reply record and byte counter.
    t_slot_rec  r_rep;
    logic [7:0] r_rep_slot;
    logic       r_lack;
    logic [3:0] r_out_cnt;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_rep) begin
            r_rep      <= rd_rec;
            r_rep_slot <= 8'(r_idx) + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lack    <= 1'b0;
            r_out_cnt <= '0;
        end else if (i_ctl.out_start) begin
            r_lack    <= i_ctl.out_lack;
            r_out_cnt <= '0;
        end else if (i_ctl.out_next) begin
            r_out_cnt <= r_out_cnt + 4'd1;
        end
    end

    // Reply bytes. The track byte is 4, plus 1 with power on, plus 2 if any
    // addressed slot is moving.
    logic [7:0] e7 [14];
    logic [7:0] chk;

    always_comb begin
        e7[0]  = OPC_RD_SL;
        e7[1]  = RD_LEN;
        e7[2]  = r_rep_slot;
        e7[3]  = r_rep.status;
        e7[4]  = {1'b0, r_rep.addr[6:0]};
        e7[5]  = {1'b0, r_rep.step};
        e7[6]  = {2'b0, r_rep.fwd, r_rep.func[0], r_rep.func[4:1]};
        e7[7]  = {5'b00000, 1'b1, r_moving, r_power};
        e7[8]  = 8'd0;
        e7[9]  = {1'b0, r_rep.addr[13:7]};
        e7[10] = 8'd0;
        e7[11] = 8'd0;
        e7[12] = 8'd0;
        chk = CHK_GOOD;
        for (int k = 0; k < 13; k++) begin
            chk = chk ^ e7[k];
        end
        e7[13] = chk;
    end

    always_comb begin
        if (r_lack) begin
            case (r_out_cnt[1:0])
                2'd0:    o_reply_byte = OPC_LACK;
                2'd1:    o_reply_byte = LACK_OPC_ECHO;
                2'd2:    o_reply_byte = LACK_CODE;
                default: o_reply_byte = LACK_CHK;
            endcase
            o_reply_last = (r_out_cnt == LACK_LAST);
        end else begin
            o_reply_byte = (r_out_cnt <= E7_LAST) ? e7[r_out_cnt] : 8'd0;
            o_reply_last = (r_out_cnt == E7_LAST);
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.dec_cmd     = dec_cmd;
        o_stat.cmd         = r_cmd;
        o_stat.eom         = i_end_of_message;
        o_stat.scan_last   = (r_scan == IDX_W'(NUM_SLOTS - 1));
        o_stat.match_found = r_match_found;
        o_stat.free_found  = r_free_found;
        o_stat.out_last    = o_reply_last;
    end

endmodule

// ----- rtl/loconet_slot_message_engine_unit.sv -----
// ----------------------------------------------------------------------------
// loconet_slot_message_engine_unit
// Command station slot engine: checks message bytes, updates the slot table
// and track power, and sends slot read or failure replies.
// ----------------------------------------------------------------------------
//  Channel | Handshake                 | Payload
//  in      | i_in_valid / o_in_stall   | i_in_byte, i_end_of_message
//  out     | o_out_valid / i_out_stall | o_reply_byte, o_reply_last
//
// Bytes that do not end a message are taken one per cycle. Power messages
// and slot writes end without a reply; a slot read scans the table before
// its reply, a null move writes its slot and then scans, and an address
// request scans for a match or a free slot, writes a free one and scans
// again, or replies with a failure if neither is found. Reply bytes go out
// one per cycle while i_out_stall is low. The table scans use one read port.
// Bytes are refused while a message is worked on or its reply transfers.
// Reset is synchronous and clears the table valid bits.
// ----------------------------------------------------------------------------
module loconet_slot_message_engine_unit import lsme_pkg::*; #(
    parameter int NUM_SLOTS = LSME_NUM_SLOTS,
    parameter int MSG_BYTES = LSME_MSG_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_message,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_reply_byte,
    output logic       o_reply_last
);

    t_ctl  ctl;
    t_stat stat;

    // Sequencer.
    lsme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_ctl       (ctl),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Datapath.
    lsme_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .MSG_BYTES (MSG_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .i_in_byte        (i_in_byte),
        .i_end_of_message (i_end_of_message),
        .o_stat           (stat),
        .o_reply_byte     (o_reply_byte),
        .o_reply_last     (o_reply_last)
    );

endmodule
